[design/lfupr_pkg.sv]
// Package for the LFU page replacement block (LRU tie-break).
// Holds sizes, field widths and the structs that pass between the top level and the frame cells.
// No dependencies.
`timescale 1ns / 1ps

package lfupr_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int PAGE_COUNT = 64;

    localparam int PAGE_W = $clog2(PAGE_COUNT);
    localparam int SLOT_W = $clog2(MAX_FRAMES);
    localparam int FC_W   = $clog2(MAX_FRAMES + 1);
    localparam int CFG_W  = 5;
    localparam int CNT_W  = 16;
    localparam int LU_W   = 32;
    localparam int FLT_W  = 16;

    localparam logic [CFG_W-1:0] FC_RESET = CFG_W'(4);

    // victim candidate handed from cell to cell
    typedef struct packed {
        logic              vld;
        logic [CNT_W-1:0]  cnt;
        logic [LU_W-1:0]   lu;
        logic [SLOT_W-1:0] idx;
        logic [PAGE_W-1:0] page;
    } cand_t;

    // broadcast command from the sequencer to every cell
    typedef struct packed {
        logic              load;
        logic              touch;
        logic [SLOT_W-1:0] slot;
        logic [PAGE_W-1:0] page;
        logic [CNT_W-1:0]  cnt;
        logic [LU_W-1:0]   lu;
    } cell_cmd_t;

endpackage

[design/lfupr_stat_mem.sv]
// Per-page reference count store, one read and one write port.
// Valid bits make never-touched pages read as zero. Depends on lfupr_pkg.
`timescale 1ns / 1ps

module lfupr_stat_mem (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        rd_en,
    input  logic [lfupr_pkg::PAGE_W-1:0] rd_addr,
    output logic [lfupr_pkg::CNT_W-1:0]  rd_cnt,
    input  logic                        wr_en,
    input  logic [lfupr_pkg::PAGE_W-1:0] wr_addr,
    input  logic [lfupr_pkg::CNT_W-1:0]  wr_cnt
);
    import lfupr_pkg::*;

    logic [CNT_W-1:0]      cnt_mem [PAGE_COUNT];
    logic [PAGE_COUNT-1:0] vld_reg;
    logic [CNT_W-1:0]      rd_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cnt_mem[wr_addr] <= wr_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_cnt_reg <= vld_reg[rd_addr] ? cnt_mem[rd_addr] : '0;
        end
    end

    assign rd_cnt = rd_cnt_reg;

endmodule

[design/lfupr_cell.sv]
// One frame cell: resident page plus a copy of its count and stamp.
// Compares against the broadcast page and passes the best victim candidate on. Depends on lfupr_pkg.
`timescale 1ns / 1ps

module lfupr_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [lfupr_pkg::SLOT_W-1:0] cell_idx,
    input  logic                         active,
    input  lfupr_pkg::cell_cmd_t         cmd,
    input  lfupr_pkg::cand_t             cand_in,
    output lfupr_pkg::cand_t             cand_out,
    output logic                         match
);
    import lfupr_pkg::*;

    logic [PAGE_W-1:0] page_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [LU_W-1:0]   lu_reg;
    cand_t             cand_reg;
    cand_t             cand_next;
    logic              better;

    assign match = (page_reg == cmd.page);

    // strict compare keeps the lower frame on a full tie
    assign better = (cnt_reg < cand_in.cnt) ||
                    ((cnt_reg == cand_in.cnt) && (lu_reg < cand_in.lu));

    always_comb begin
        cand_next = cand_in;
        if (active && (!cand_in.vld || better)) begin
            cand_next.vld  = 1'b1;
            cand_next.cnt  = cnt_reg;
            cand_next.lu   = lu_reg;
            cand_next.idx  = cell_idx;
            cand_next.page = page_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && (cmd.slot == cell_idx)) begin
            page_reg <= cmd.page;
            cnt_reg  <= cmd.cnt;
            lu_reg   <= cmd.lu;
        end else if (cmd.touch && match) begin
            cnt_reg  <= cmd.cnt;
            lu_reg   <= cmd.lu;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_reg <= '0;
        end else begin
            cand_reg <= cand_next;
        end
    end

    assign cand_out = cand_reg;

endmodule

[design/lfu_page_replacement_lru_tiebreak.sv]
// LFU page replacement with LRU tie-break, one page reference per word.
// A word goes from accept through LOOK to WRITE on a hit or a fill into a free frame, and through
// SEARCH on an eviction (the victim candidate walks the 16-cell frame chain, one cell per cycle).
// One word in flight: the next word is taken only once WRITE has handed its result to the output.
// Reset (aresetn low, synchronous): frames empty, counts read as zero, time and fault total
// zero, frame_count back to 4. No clearing pass; the block is ready right away.
`timescale 1ns / 1ps

module lfu_page_replacement_lru_tiebreak (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: frame_count
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    // page reference stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [5:0] page, [7:6] zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [0] hit, [4:1] slot, [5] evicted_valid,
                                   // [11:6] evicted_page, [27:12] fault_total, [31:28] zero
);
    import lfupr_pkg::*;

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOK   = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_WRITE  = 2'd3;

    localparam logic [SLOT_W-1:0] SCAN_LAST = SLOT_W'(MAX_FRAMES - 1);
    localparam logic [FC_W-1:0]   FC_MAX    = FC_W'(MAX_FRAMES);

    logic [1:0]        state_reg, state_next;
    logic [CFG_W-1:0]  frame_count_reg;
    logic [FC_W-1:0]   filled_reg;
    logic [LU_W-1:0]   time_reg;
    logic [FLT_W-1:0]  faults_reg, faults_next;
    logic [SLOT_W-1:0] scan_reg;

    // per-word working registers
    logic [PAGE_W-1:0] pg_reg;
    logic              hit_reg;
    logic              evict_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [CNT_W-1:0]  cnt_new_reg;

    // output register
    logic              m_valid_reg;
    logic [31:0]       m_data_reg;

    // count memory; stamps live only in the cell copies
    logic [CNT_W-1:0]  rd_cnt;

    // cell chain
    cand_t                 cand [MAX_FRAMES+1];
    logic [MAX_FRAMES-1:0] match;
    logic [MAX_FRAMES-1:0] active;
    cell_cmd_t             cmd;

    logic [FC_W-1:0]   fc_use;
    logic [FC_W-1:0]   used;
    logic              has_free;
    logic              look_hit;
    logic [SLOT_W-1:0] look_slot;
    logic              out_free;
    logic              do_write;
    logic [SLOT_W-1:0] wr_slot;
    logic [PAGE_W-1:0] ev_page;
    logic              in_accept;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_tready;
    assign do_write  = (state_reg == ST_WRITE) && out_free;

    // frame count in use: zero acts as one, above the frame total clamps
    always_comb begin
        priority if (frame_count_reg == '0) begin
            fc_use = FC_W'(1);
        end else if (FC_W'(frame_count_reg) > FC_MAX) begin
            fc_use = FC_MAX;
        end else begin
            fc_use = FC_W'(frame_count_reg);
        end
    end

    assign used     = (filled_reg < fc_use) ? filled_reg : fc_use;
    assign has_free = (filled_reg < fc_use);

    // hit lookup over filled frames, lowest matching frame wins
    always_comb begin
        look_hit  = 1'b0;
        look_slot = '0;
        for (int k = MAX_FRAMES - 1; k >= 0; k--) begin
            if (match[k] && (FC_W'(k) < used)) begin
                look_hit  = 1'b1;
                look_slot = SLOT_W'(k);
            end
        end
    end

    // victim comes out of the last cell of the chain
    assign wr_slot = evict_reg ? cand[MAX_FRAMES].idx  : slot_reg;
    assign ev_page = evict_reg ? cand[MAX_FRAMES].page : '0;

    always_comb begin
        cmd       = '0;
        cmd.load  = do_write && !hit_reg;
        cmd.touch = do_write;
        cmd.slot  = wr_slot;
        cmd.page  = pg_reg;
        cmd.cnt   = cnt_new_reg;
        cmd.lu    = time_reg;
    end

    assign faults_next = (!hit_reg && (faults_reg != '1)) ? faults_reg + FLT_W'(1) : faults_reg;

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) state_next = ST_LOOK;
            end
            ST_LOOK: begin
                if (look_hit || has_free) state_next = ST_WRITE;
                else                      state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (scan_reg == SCAN_LAST) state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            frame_count_reg <= FC_RESET;
            filled_reg      <= '0;
            time_reg        <= '0;
            faults_reg      <= '0;
            scan_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) frame_count_reg <= cfg_wr_data;
            if (state_reg == ST_SEARCH) scan_reg <= scan_reg + SLOT_W'(1);
            else                        scan_reg <= '0;
            if (do_write) begin
                time_reg    <= time_reg + LU_W'(1);
                faults_reg  <= faults_next;
                m_valid_reg <= 1'b1;
                if (!hit_reg && !evict_reg) filled_reg <= filled_reg + FC_W'(1);
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_accept) pg_reg <= s_tdata[PAGE_W-1:0];
        if (state_reg == ST_LOOK) begin
            hit_reg     <= look_hit;
            evict_reg   <= !look_hit && !has_free;
            slot_reg    <= look_hit ? look_slot : filled_reg[SLOT_W-1:0];
            cnt_new_reg <= (rd_cnt == '1) ? rd_cnt : rd_cnt + CNT_W'(1);
        end
        if (do_write) begin
            m_data_reg <= {4'b0, faults_next, ev_page, evict_reg, wr_slot, hit_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    lfupr_stat_mem u_stat (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (in_accept),
        .rd_addr (s_tdata[PAGE_W-1:0]),
        .rd_cnt  (rd_cnt),
        .wr_en   (do_write),
        .wr_addr (pg_reg),
        .wr_cnt  (cnt_new_reg)
    );

    // the chain starts with no candidate; inactive cells pass it through
    assign cand[0] = '0;

    for (genvar k = 0; k < MAX_FRAMES; k++) begin : g_cell
        assign active[k] = (FC_W'(k) < fc_use);

        lfupr_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (SLOT_W'(k)),
            .active   (active[k]),
            .cmd      (cmd),
            .cand_in  (cand[k]),
            .cand_out (cand[k+1]),
            .match    (match[k])
        );
    end

    // ---- assertions ----
    a_filled_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg <= FC_MAX)
        else $error("filled frame count beyond frame total");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg[0] && m_data_reg[5]))
        else $error("result reports both hit and eviction");

    a_accept_look: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> (state_reg == ST_LOOK))
        else $error("accepted word did not enter lookup");

    a_evict_valid_cand: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_write && evict_reg) |-> cand[MAX_FRAMES].vld)
        else $error("eviction without a victim candidate");

endmodule
